### hw/rtl/calc_pkg.sv
// Package: operation codes, widths and the controller/datapath command and status types.
package calc_pkg;

	localparam int OperandWidth = 32;
	localparam int ValueWidth   = 64;
	localparam int OpWidth      = 3;
	// divide numerator: 2*|a|*100 plus |b| fits in 41 bits
	localparam int NumWidth     = 41;
	localparam int DivSteps     = NumWidth;
	localparam int DivCntWidth  = $clog2(DivSteps + 1);
	localparam int ExpCntWidth  = $clog2(OperandWidth + 1);

	typedef enum logic [OpWidth-1:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_POW = 3'd4,
		OP_MOD = 3'd5,
		OP_BAD6 = 3'd6,
		OP_BAD7 = 3'd7
	} op_t;

	typedef struct packed {
		logic load;       // capture operands, set up the selected unit
		logic div_step;   // one restoring-division bit
		logic pow_mul;    // acc *= base where the exponent bit is set
		logic pow_sq;     // base *= base, shift exponent
		logic finish;     // form the result word
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic pow_done;
		logic mul_half;   // partial product phase of a 64-bit multiply
		logic exp_lsb;    // current low bit of the exponent
	} status_t;

endpackage

### hw/rtl/calc_if.sv
// Valid/ready channel interface carrying one beat of payload.
interface calc_if #(parameter type payload_t = logic) (input logic clk);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/calc_dp.sv
// Datapath: operand registers, shared restoring divider and 64-bit power unit.
module calc_dp (
	input  logic                                  clk,
	input  calc_pkg::cmd_t                        cmd,
	output calc_pkg::status_t                     status,
	input  logic signed [calc_pkg::OperandWidth-1:0] a_in,
	input  logic signed [calc_pkg::OperandWidth-1:0] b_in,
	input  calc_pkg::op_t                         op_in,
	output logic signed [calc_pkg::ValueWidth-1:0] value,
	output logic                                  in_hundredths,
	output logic                                  error
);
	localparam int W  = calc_pkg::OperandWidth;
	localparam int VW = calc_pkg::ValueWidth;
	localparam int NW = calc_pkg::NumWidth;

	logic signed [W-1:0] a_q, b_q;
	calc_pkg::op_t op_q;
	logic [NW-1:0] num_q, den_q, rem_q, quo_q;
	logic [calc_pkg::DivCntWidth-1:0] dcnt_q;
	logic [VW-1:0] base_q, acc_q;
	logic [W-1:0] exp_q;
	logic [VW-1:0] pp_q;       // low 32x32 product
	logic phase_q;             // 0: low product, 1: cross terms
	logic [W-1:0] mag_a, mag_b;
	logic [NW:0] rem_sh, rem_sub;
	logic [VW-1:0] mul_x, mul_y, half_prod, lo_prod;
	logic [W-1:0] mid_sum;
	logic [VW-1:0] result;
	logic [W-1:0] arith;

	assign mag_a = a_in[W-1] ? W'(-a_in) : W'(a_in);
	assign mag_b = b_in[W-1] ? W'(-b_in) : W'(b_in);
	assign rem_sh  = {rem_q, num_q[NW-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};

	// 64x64 wrap in phases: low 32x32 product, then the two cross terms
	assign mul_x = cmd.pow_mul ? acc_q : base_q;
	assign mul_y = base_q;
	assign lo_prod = mul_x[W-1:0] * mul_y[W-1:0];
	assign mid_sum = mul_x[W-1:0] * mul_y[VW-1:W] + mul_x[VW-1:W] * mul_y[W-1:0];
	assign half_prod = phase_q ? {mid_sum, {W{1'b0}}} : lo_prod;
	assign status.mul_half = phase_q;
	assign status.div_done = (dcnt_q == '0);
	assign status.pow_done = (exp_q == '0);
	assign status.exp_lsb  = exp_q[0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= a_in;
			b_q <= b_in;
			op_q <= op_in;
			phase_q <= 1'b0;
			dcnt_q <= calc_pkg::DivCntWidth'(calc_pkg::DivSteps);
			rem_q <= '0;
			quo_q <= '0;
			den_q <= (op_in == calc_pkg::OP_DIV) ? NW'({mag_b, 1'b0}) : NW'(mag_b);
			num_q <= (op_in == calc_pkg::OP_DIV)
				? NW'(NW'(mag_a) * NW'(200) + NW'(mag_b)) : NW'(mag_a);
			base_q <= VW'(a_in);
			acc_q <= VW'(1);
			exp_q <= b_in[W-1] ? '0 : W'(b_in);
		end else if (cmd.div_step) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			dcnt_q <= dcnt_q - 1'b1;
			if (!rem_sub[NW]) begin
				rem_q <= rem_sub[NW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[NW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end else if (cmd.pow_mul || cmd.pow_sq) begin
			if (!phase_q) begin
				pp_q <= half_prod;
				phase_q <= 1'b1;
			end else begin
				phase_q <= 1'b0;
				if (cmd.pow_mul) begin
					acc_q <= pp_q + half_prod;
				end else begin
					base_q <= pp_q + half_prod;
					exp_q <= exp_q >> 1;
				end
			end
		end
		if (cmd.finish) begin
			value <= result;
			in_hundredths <= (op_q == calc_pkg::OP_DIV) && (b_q != '0);
			error <= ((op_q == calc_pkg::OP_DIV || op_q == calc_pkg::OP_MOD) && b_q == '0)
				|| op_q == calc_pkg::OP_BAD6 || op_q == calc_pkg::OP_BAD7;
		end
	end

	always_comb begin
		arith = '0;
		result = '0;
		case (op_q)
			calc_pkg::OP_ADD: begin
				arith = W'(a_q + b_q);
				result = VW'(signed'(arith));
			end
			calc_pkg::OP_SUB: begin
				arith = W'(a_q - b_q);
				result = VW'(signed'(arith));
			end
			calc_pkg::OP_MUL: begin
				arith = W'(a_q * b_q);
				result = VW'(signed'(arith));
			end
			calc_pkg::OP_DIV: begin
				if (b_q != '0)
					result = (a_q[W-1] != b_q[W-1]) ? -VW'(quo_q) : VW'(quo_q);
			end
			calc_pkg::OP_POW: result = acc_q;
			calc_pkg::OP_MOD: begin
				if (b_q != '0)
					result = a_q[W-1] ? -VW'(rem_q) : VW'(rem_q);
			end
			default: result = '0;
		endcase
	end
endmodule

### hw/rtl/calc_ctrl.sv
// Controller: sequences load, divide steps, power multiplies and result handoff.
module calc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  calc_pkg::op_t     op_in,
	output logic              out_valid,
	input  logic              out_ready,
	output calc_pkg::cmd_t    cmd,
	input  calc_pkg::status_t status
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_DIV  = 6'b000010,
		S_PMUL = 6'b000100,
		S_PSQ  = 6'b001000,
		S_FIN  = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (op_in == calc_pkg::OP_DIV || op_in == calc_pkg::OP_MOD)
						state_d = S_DIV;
					else if (op_in == calc_pkg::OP_POW)
						state_d = S_PMUL;
					else
						state_d = S_FIN;
				end
			end
			S_DIV: begin
				if (status.div_done) state_d = S_FIN;
				else cmd.div_step = 1'b1;
			end
			S_PMUL: begin
				if (status.pow_done) state_d = S_FIN;
				else if (!status.exp_lsb) state_d = S_PSQ;
				else begin
					cmd.pow_mul = 1'b1;
					if (status.mul_half) state_d = S_PSQ;
				end
			end
			S_PSQ: begin
				cmd.pow_sq = 1'b1;
				if (status.mul_half) state_d = S_PMUL;
			end
			S_FIN: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule

### hw/rtl/calculator_alu.sv
// Top level: integer ALU with add, subtract, multiply, divide, power and modulo.
//
// Input channel "req" carries operand_a, operand_b (signed 32-bit) and operation.
// Output channel "rsp" carries value (signed 64-bit), in_hundredths and error.
// A beat is taken on req when valid and ready are both high; one rsp beat follows.
// Work per request, from the req beat to rsp valid:
//   add, sub, mul and invalid codes: straight from the load to the result.
//   divide and modulo: the 41-step restoring divider.
//   power: a square per exponent bit and a multiply where the bit is set (up to
//   31 bits, the exponent is not negative), each a 64-bit multiply built from
//   a low 32x32 product and then the cross terms.
// One request is in work at a time; req ready is high only while idle, so the
// next req beat can be taken in the cycle after the result is handed off.
// The result sits in an output register: the block goes idle and takes the
// next req beat while the last rsp beat still waits to be taken.
// If rsp stalls when a new result is done, the finished item holds in the
// datapath until the output register frees.
// Reset clears the controller and rsp valid; payload registers are not reset.
module calculator_alu (
	input logic clk,
	input logic arst_n,
	calc_if.sink   req,
	calc_if.source rsp
);
	calc_pkg::cmd_t    cmd;
	calc_pkg::status_t status;
	logic signed [calc_pkg::ValueWidth-1:0] value;
	logic in_hundredths, error;

	calc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready),
		.op_in(calc_pkg::op_t'(req.data.operation)),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.cmd(cmd), .status(status)
	);

	calc_dp u_dp (
		.clk(clk), .cmd(cmd), .status(status),
		.a_in(req.data.operand_a), .b_in(req.data.operand_b),
		.op_in(calc_pkg::op_t'(req.data.operation)),
		.value(value), .in_hundredths(in_hundredths), .error(error)
	);

	assign rsp.data.value = value;
	assign rsp.data.in_hundredths = in_hundredths;
	assign rsp.data.error = error;

	// hold rsp payload while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data.value))
		else $error("rsp dropped while stalled");
	// finish only with room in the output register
	a_fin: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!rsp.valid || rsp.ready))
		else $error("result overwrote pending beat");
	// commands are exclusive
	a_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd)) else $error("conflicting commands");
	// a load only on an accepted beat
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> req.valid && req.ready) else $error("load without beat");
endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for calculator_alu: directed and random requests checked against an in-bench predictor.
module tb_top;

	typedef struct packed {
		logic signed [calc_pkg::OperandWidth-1:0] operand_a;
		logic signed [calc_pkg::OperandWidth-1:0] operand_b;
		calc_pkg::op_t                            operation;
	} alu_req_t;

	typedef struct packed {
		logic signed [calc_pkg::ValueWidth-1:0] value;
		logic                                   in_hundredths;
		logic                                   error;
	} alu_rsp_t;

	localparam int RandomItems = 1030;
	localparam int QuietAfter  = 900;    // accepted requests before idling stops
	localparam int LongHoldAt  = 300;    // accepted requests before the long rsp stall
	localparam int LongHoldLen = 600;

	logic clk;
	logic arst_n;

	calc_if #(.payload_t(alu_req_t)) req (.clk(clk));
	calc_if #(.payload_t(alu_rsp_t)) rsp (.clk(clk));

	calculator_alu uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	alu_req_t pending_reqs[$];
	alu_rsp_t expected_rsps[$];
	int       n_accepted;
	int       n_checked;
	int       n_errors;
	int       n_total;
	int       send_gap;
	int       ready_gap;
	int       long_hold;
	bit       long_hold_done;
	bit       req_taken;

	// Clock and the single reset pulse at the start.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Magnitude of a 64-bit two's complement pattern.
	function automatic logic [63:0] mag64(logic [63:0] v);
		return v[63] ? (64'd0 - v) : v;
	endfunction

	// Compute what the ALU should return for one request.
	function automatic alu_rsp_t alu_predict(alu_req_t r);
		alu_rsp_t    res;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] na;
		logic [63:0] nb;
		logic [63:0] q;
		logic [63:0] base;
		logic [63:0] acc;
		logic [31:0] e;
		a = {{32{r.operand_a[31]}}, r.operand_a};
		b = {{32{r.operand_b[31]}}, r.operand_b};
		res = '0;
		case (r.operation)
			calc_pkg::OP_ADD: res.value = 64'(signed'(32'(a + b)));
			calc_pkg::OP_SUB: res.value = 64'(signed'(32'(a - b)));
			calc_pkg::OP_MUL: res.value = 64'(signed'(32'(a * b)));
			calc_pkg::OP_DIV: begin
				if (b == 64'd0) begin
					res.error = 1'b1;
				end else begin
					na = mag64(a) * 64'd100;
					nb = mag64(b);
					q = (64'd2 * na + nb) / (64'd2 * nb);
					res.value = (a[63] != b[63]) ? (64'd0 - q) : q;
					res.in_hundredths = 1'b1;
				end
			end
			calc_pkg::OP_POW: begin
				// square and multiply, wrapping at 64 bits; negative exponent gives one
				acc = 64'd1;
				if (!b[63]) begin
					base = a;
					e = b[31:0];
					while (e != 32'd0) begin
						if (e[0])
							acc = acc * base;
						base = base * base;
						e = e >> 1;
					end
				end
				res.value = acc;
			end
			calc_pkg::OP_MOD: begin
				if (b == 64'd0) begin
					res.error = 1'b1;
				end else begin
					q = mag64(a) % mag64(b);
					res.value = a[63] ? (64'd0 - q) : q;
				end
			end
			default: res.error = 1'b1;
		endcase
		return res;
	endfunction

	// Pick an operand: full range or small equally often, sometimes an extreme.
	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'(signed'($urandom_range(0, 6)) - 3);
			3, 4, 5: return 32'(signed'($urandom_range(0, 2000)) - 1000);
			default: return $urandom;
		endcase
	endfunction

	function automatic alu_req_t make_req(logic [31:0] a, logic [31:0] b, calc_pkg::op_t op);
		alu_req_t r;
		r.operand_a = a;
		r.operand_b = b;
		r.operation = op;
		return r;
	endfunction

	// Request driver: change inputs at the falling edge, advance only after a beat.
	initial begin
		req.valid = 1'b0;
		req.data  = '0;
		rsp.ready = 1'b0;
	end

	always @(negedge clk) begin
		if (arst_n && (!req.valid || req_taken)) begin
			if (send_gap > 0) begin
				req.valid <= 1'b0;
				send_gap--;
			end else if (pending_reqs.size() != 0) begin
				req.data  <= pending_reqs.pop_front();
				req.valid <= 1'b1;
				// occasionally idle after this beat
				if (n_accepted < QuietAfter && $urandom_range(0, 5) == 0)
					send_gap = $urandom_range(1, 10);
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// Response sink: random stall bursts, one long hold-off to back the block up.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (long_hold > 0) begin
			rsp.ready <= 1'b0;
			long_hold--;
		end else if (!long_hold_done && n_accepted >= LongHoldAt) begin
			long_hold_done = 1'b1;
			long_hold = LongHoldLen;
			rsp.ready <= 1'b0;
		end else if (ready_gap > 0) begin
			rsp.ready <= 1'b0;
			ready_gap--;
		end else begin
			rsp.ready <= 1'b1;
			if (n_accepted < QuietAfter && $urandom_range(0, 4) == 0)
				ready_gap = $urandom_range(1, 10);
		end
	end

	// Monitor: sample at the rising edge, predict on each req beat, check each rsp beat.
	always @(posedge clk) begin
		alu_rsp_t exp_rsp;
		req_taken <= arst_n && req.valid && req.ready;
		if (arst_n && req.valid && req.ready) begin
			expected_rsps.push_back(alu_predict(req.data));
			n_accepted++;
		end
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_rsps.size() == 0) begin
				$error("rsp beat with nothing expected: value %0d", rsp.data.value);
				n_errors++;
			end else begin
				exp_rsp = expected_rsps.pop_front();
				n_checked++;
				if (rsp.data.value !== exp_rsp.value) begin
					$error("value: expected %0d, actual %0d", exp_rsp.value, rsp.data.value);
					n_errors++;
				end
				if (rsp.data.in_hundredths !== exp_rsp.in_hundredths) begin
					$error("in_hundredths: expected %0b, actual %0b",
						exp_rsp.in_hundredths, rsp.data.in_hundredths);
					n_errors++;
				end
				if (rsp.data.error !== exp_rsp.error) begin
					$error("error: expected %0b, actual %0b", exp_rsp.error, rsp.data.error);
					n_errors++;
				end
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		n_accepted = 0;
		n_checked = 0;
		n_errors = 0;
		n_total = 0;
		send_gap = 0;
		ready_gap = 0;
		long_hold = 0;
		long_hold_done = 1'b0;
		req_taken = 1'b0;

		// directed: wrap points, rounding halves, zero divisors, odd powers, bad codes
		pending_reqs.push_back(make_req(32'h7fff_ffff, 32'd1, calc_pkg::OP_ADD));
		pending_reqs.push_back(make_req(32'h8000_0000, 32'hffff_ffff, calc_pkg::OP_ADD));
		pending_reqs.push_back(make_req(32'h8000_0000, 32'd1, calc_pkg::OP_SUB));
		pending_reqs.push_back(make_req(32'h7fff_ffff, 32'h8000_0000, calc_pkg::OP_SUB));
		pending_reqs.push_back(make_req(32'h7fff_ffff, 32'h7fff_ffff, calc_pkg::OP_MUL));
		pending_reqs.push_back(make_req(32'h8000_0000, 32'hffff_ffff, calc_pkg::OP_MUL));
		pending_reqs.push_back(make_req(32'd7, 32'd2, calc_pkg::OP_DIV));
		pending_reqs.push_back(make_req(32'd1, 32'd200, calc_pkg::OP_DIV));
		pending_reqs.push_back(make_req(32'hffff_ffff, 32'd200, calc_pkg::OP_DIV));
		pending_reqs.push_back(make_req(32'd1, 32'd201, calc_pkg::OP_DIV));
		pending_reqs.push_back(make_req(32'h8000_0000, 32'hffff_ffff, calc_pkg::OP_DIV));
		pending_reqs.push_back(make_req(32'h7fff_ffff, 32'h8000_0000, calc_pkg::OP_DIV));
		pending_reqs.push_back(make_req(32'd5, 32'd0, calc_pkg::OP_DIV));
		pending_reqs.push_back(make_req(32'd5, 32'd0, calc_pkg::OP_MOD));
		pending_reqs.push_back(make_req(32'h8000_0000, 32'hffff_ffff, calc_pkg::OP_MOD));
		pending_reqs.push_back(make_req(32'hffff_fff9, 32'd2, calc_pkg::OP_MOD));
		pending_reqs.push_back(make_req(32'd7, 32'hffff_fffe, calc_pkg::OP_MOD));
		pending_reqs.push_back(make_req(32'd2, 32'd63, calc_pkg::OP_POW));
		pending_reqs.push_back(make_req(32'd3, 32'hffff_ffff, calc_pkg::OP_POW));
		pending_reqs.push_back(make_req(32'd9, 32'd0, calc_pkg::OP_POW));
		pending_reqs.push_back(make_req(32'hffff_ffff, 32'h7fff_ffff, calc_pkg::OP_POW));
		pending_reqs.push_back(make_req(32'h8000_0000, 32'd2, calc_pkg::OP_POW));
		pending_reqs.push_back(make_req(32'h7fff_ffff, 32'h7fff_ffff, calc_pkg::OP_POW));
		pending_reqs.push_back(make_req(32'd1, 32'd2, calc_pkg::OP_BAD6));
		pending_reqs.push_back(make_req(32'd1, 32'd2, calc_pkg::OP_BAD7));

		// random: every code, mixed operand shapes
		repeat (RandomItems)
			pending_reqs.push_back(make_req(pick_operand(), pick_operand(),
				calc_pkg::op_t'($urandom_range(0, 7))));
		n_total = pending_reqs.size();

		wait (arst_n);
		wait (n_checked == n_total);
		repeat (150) @(posedge clk);

		$display("Covered %0d requests over all operation codes, %0d results checked.",
			n_accepted, n_checked);
		if (n_errors == 0 && expected_rsps.size() == 0 && n_checked == n_total)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#6ms;
		$display("FAIL");
		$finish;
	end

endmodule
